// ===== sv/huffman_code_bit_packer_core_defines.svh =====
// ----------------------------------------------------------------------------
// Huffman code bit packer assertion macros
// Shared concurrent assertion forms, clocked on clk and gated by arst_n.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BIT_PACKER_CORE_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_CORE_DEFINES_SVH

// same-cycle implication
`define HBP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hbp assertion failed");

// next-cycle implication
`define HBP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hbp assertion failed");

`endif

// ===== sv/hbp_pkg.sv =====
// ----------------------------------------------------------------------------
// Huffman code bit packer package
// Item modes, code table entry type and fixed field widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hbp_pkg;

	typedef enum logic [2:0] {
		MODE_COUNT  = 3'd0,
		MODE_ENTRY  = 3'd1,
		MODE_LENGTH = 3'd2,
		MODE_DATA   = 3'd3,
		MODE_FLUSH  = 3'd4
	} mode_t;

	localparam int SYMBOL_BITS    = 8;
	localparam int CODE_LEN_BITS  = 3;
	localparam int MAX_CODE_BITS  = 7;
	localparam int COUNT_IN_BITS  = 5;
	localparam int STREAM_IN_BITS = 30;
	localparam int BYTE_BITS      = 8;
	localparam int TABLE_DEPTH    = 256;
	// power of two, pointers wrap naturally
	localparam int QUEUE_DEPTH    = 4;

	typedef struct packed {
		logic [CODE_LEN_BITS-1:0] len;
		logic [MAX_CODE_BITS-1:0] code;
	} entry_t;

endpackage

// ===== sv/hbp_front.sv =====
// ----------------------------------------------------------------------------
// Huffman code bit packer front end
// Accepts items, keeps the code table and turns each item into a bit group.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "huffman_code_bit_packer_core_defines.svh"

module hbp_front #(
	parameter int COUNT_FIELD_BITS   = 5,
	parameter int LENGTH_FIELD_BITS  = 3,
	parameter int STREAM_LENGTH_BITS = 30,
	parameter int PUSH_W             = 32,
	parameter int LEN_W              = 6
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [2:0]                           mode,
	input  logic [hbp_pkg::SYMBOL_BITS-1:0]      symbol,
	input  logic [hbp_pkg::CODE_LEN_BITS-1:0]    code_length,
	input  logic [hbp_pkg::MAX_CODE_BITS-1:0]    code_bits,
	input  logic [hbp_pkg::COUNT_IN_BITS-1:0]    entry_count,
	input  logic [hbp_pkg::STREAM_IN_BITS-1:0]   stream_length,
	output logic                                 job_valid,
	input  logic                                 job_ready,
	output logic                                 job_flush,
	output logic [LEN_W-1:0]                     job_len,
	output logic [PUSH_W-1:0]                    job_bits
);

	localparam int EXT_W = (PUSH_W > hbp_pkg::STREAM_IN_BITS) ? PUSH_W
		: hbp_pkg::STREAM_IN_BITS;

	logic                                  in_acc;
	logic                                  known;
	logic                                  flush_d;
	logic                                  lookup_d;
	logic [PUSH_W-1:0]                     bits_d;
	logic [LEN_W-1:0]                      len_d;
	logic [hbp_pkg::MAX_CODE_BITS-1:0]     code_mask;
	logic [hbp_pkg::MAX_CODE_BITS-1:0]     code_masked;
	logic [PUSH_W-1:0]                     count_ext;
	logic [PUSH_W-1:0]                     count_cut;
	logic [EXT_W-1:0]                      slen_ext;
	logic [EXT_W-1:0]                      slen_cut;
	logic [PUSH_W-1:0]                     entry_hdr;

	hbp_pkg::entry_t                       table_mem [hbp_pkg::TABLE_DEPTH];
	logic [hbp_pkg::TABLE_DEPTH-1:0]       vld_q;

	logic                                  v_s1;
	logic                                  flush_s1;
	logic                                  lookup_s1;
	logic [PUSH_W-1:0]                     bits_s1;
	logic [LEN_W-1:0]                      len_s1;
	hbp_pkg::entry_t                       rd_s1;
	logic                                  rd_vld_s1;

	assign in_stall = v_s1 && !job_ready;
	assign in_acc   = in_valid && !in_stall;

	// only the low code_length bits of the code count
	assign code_mask   = {hbp_pkg::MAX_CODE_BITS{1'b1}} >> (3'd7 - code_length);
	assign code_masked = code_bits & code_mask;

	assign count_ext = PUSH_W'(entry_count);
	assign count_cut = (count_ext << (PUSH_W - COUNT_FIELD_BITS)) >> (PUSH_W - COUNT_FIELD_BITS);
	assign slen_ext  = EXT_W'(stream_length);
	assign slen_cut  = (slen_ext << (EXT_W - STREAM_LENGTH_BITS))
		>> (EXT_W - STREAM_LENGTH_BITS);
	assign entry_hdr = PUSH_W'({symbol, LENGTH_FIELD_BITS'(code_length)});

	always_comb begin
		known    = 1'b1;
		flush_d  = 1'b0;
		lookup_d = 1'b0;
		bits_d   = '0;
		len_d    = '0;
		case (hbp_pkg::mode_t'(mode))
			hbp_pkg::MODE_COUNT: begin
				bits_d = count_cut;
				len_d  = LEN_W'(COUNT_FIELD_BITS);
			end
			hbp_pkg::MODE_ENTRY: begin
				bits_d = (entry_hdr << code_length) | PUSH_W'(code_masked);
				len_d  = LEN_W'(hbp_pkg::SYMBOL_BITS + LENGTH_FIELD_BITS)
					+ LEN_W'(code_length);
			end
			hbp_pkg::MODE_LENGTH: begin
				bits_d = PUSH_W'(slen_cut);
				len_d  = LEN_W'(STREAM_LENGTH_BITS);
			end
			hbp_pkg::MODE_DATA: begin
				lookup_d = 1'b1;
			end
			hbp_pkg::MODE_FLUSH: begin
				flush_d = 1'b1;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	// code table: one write or one registered read per accepted item
	always_ff @(posedge clk) begin
		if (in_acc && (mode == hbp_pkg::MODE_ENTRY)) begin
			table_mem[symbol] <= '{len: code_length, code: code_masked};
		end else if (in_acc) begin
			rd_s1 <= table_mem[symbol];
		end
	end

	// entries never written read as length zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (in_acc && (mode == hbp_pkg::MODE_ENTRY)) begin
			vld_q[symbol] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid && known;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			flush_s1  <= flush_d;
			lookup_s1 <= lookup_d;
			bits_s1   <= bits_d;
			len_s1    <= len_d;
			rd_vld_s1 <= vld_q[symbol];
		end
	end

	// an unwritten entry holds no defined code, so it adds no bits at all
	assign job_valid = v_s1;
	assign job_flush = flush_s1;
	assign job_bits  = lookup_s1 ? (rd_vld_s1 ? PUSH_W'(rd_s1.code) : '0) : bits_s1;
	assign job_len   = lookup_s1 ? (rd_vld_s1 ? LEN_W'(rd_s1.len) : '0) : len_s1;

	`HBP_ASSERT_NXT(a_entry_marked, in_acc && (mode == hbp_pkg::MODE_ENTRY), vld_q[$past(symbol)])

endmodule

// ===== sv/hbp_queue.sv =====
// ----------------------------------------------------------------------------
// Huffman code bit packer bit group queue
// Short FIFO between the front end and the packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "huffman_code_bit_packer_core_defines.svh"

module hbp_queue #(
	parameter int DATA_W = 39
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data,
	output logic              empty
);

	localparam int PTR_W = $clog2(hbp_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(hbp_pkg::QUEUE_DEPTH + 1);

	logic [DATA_W-1:0] mem_q [hbp_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push_ok;
	logic              pop_ok;

	assign full     = (count_q == CNT_W'(hbp_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign push_ok  = push && !full;
	assign pop_ok   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`HBP_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(hbp_pkg::QUEUE_DEPTH))
	`HBP_ASSERT_NXT(a_count_inc, push_ok && !pop_ok, count_q == $past(count_q) + CNT_W'(1))

endmodule

// ===== sv/hbp_back.sv =====
// ----------------------------------------------------------------------------
// Huffman code bit packer back end
// Appends bit groups to the pending bits and sends out each full byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "huffman_code_bit_packer_core_defines.svh"

module hbp_back #(
	parameter int PUSH_W = 32,
	parameter int LEN_W  = 6
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            job_empty,
	input  logic                            job_flush,
	input  logic [LEN_W-1:0]                job_len,
	input  logic [PUSH_W-1:0]               job_bits,
	output logic                            job_pop,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [hbp_pkg::BYTE_BITS-1:0]   out_byte,
	output logic                            last_of_run
);

	localparam int ACC_W = PUSH_W + hbp_pkg::BYTE_BITS - 1;
	localparam int AN_W  = $clog2(ACC_W + 1);

	logic [ACC_W-1:0]                  acc_q;
	logic [AN_W-1:0]                   acc_n_q;
	logic                              out_valid_q;
	logic [hbp_pkg::BYTE_BITS-1:0]     out_byte_q;
	logic                              last_q;

	logic                              out_free;
	logic                              emit;
	logic [AN_W-1:0]                   rem_n;
	logic [AN_W-1:0]                   sh;
	logic [ACC_W-1:0]                  acc_d;
	logic [AN_W-1:0]                   acc_n_d;
	logic [ACC_W-1:0]                  top_aligned;

	assign out_free = !out_valid_q || !out_stall;
	assign emit     = (acc_n_q >= AN_W'(hbp_pkg::BYTE_BITS)) && out_free;
	assign rem_n    = emit ? (acc_n_q - AN_W'(hbp_pkg::BYTE_BITS)) : acc_n_q;
	// a new group merges only once fewer than a byte of bits is left
	assign job_pop  = !job_empty && (rem_n < AN_W'(hbp_pkg::BYTE_BITS));

	// flush pads the partial byte with zeros up to a byte boundary
	always_comb begin
		if (job_flush) begin
			sh = (rem_n == '0) ? '0 : (AN_W'(hbp_pkg::BYTE_BITS) - rem_n);
		end else begin
			sh = AN_W'(job_len);
		end
	end

	assign acc_d       = job_pop ? ((acc_q << sh) | ACC_W'(job_bits)) : acc_q;
	assign acc_n_d     = job_pop ? (rem_n + sh) : rem_n;
	assign top_aligned = acc_q >> (acc_n_q - AN_W'(hbp_pkg::BYTE_BITS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			acc_n_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			acc_q   <= acc_d;
			acc_n_q <= acc_n_d;
			if (out_free) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= top_aligned[hbp_pkg::BYTE_BITS-1:0];
			last_q     <= (rem_n < AN_W'(hbp_pkg::BYTE_BITS));
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;

	`HBP_ASSERT_IMP(a_acc_bound, 1'b1, acc_n_q <= AN_W'(ACC_W))
	`HBP_ASSERT_NXT(a_flush_aligned, job_pop && job_flush, (acc_n_q == '0) || (acc_n_q == AN_W'(hbp_pkg::BYTE_BITS)))

endmodule

// ===== sv/huffman_code_bit_packer_core.sv =====
// Packs a Huffman-coded stream into bytes, first bit in bit 7 of out_byte. A data symbol item
// is taken every cycle and gives at most one byte, so data runs at one item per clock while
// out_stall is low and the queue has room; a header item gives up to four bytes and holds the
// packer until fewer than a byte of bits is left, while the front end keeps accepting
// items into a four-deep queue until it fills. On its way to out_byte an item passes the
// front-end stage register, the queue, the packer's pending bits and the output register. The
// 256-entry code table is a single-port memory with one valid flop per entry, cleared by the
// asynchronous reset: no clearing pass is needed. last_of_run marks the final byte produced by
// an item; items that make no byte make no output.
// ----------------------------------------------------------------------------
// Huffman code bit packer core
// Top level: front end with code table, bit group queue and byte packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module huffman_code_bit_packer_core #(
	parameter int COUNT_FIELD_BITS   = 5,
	parameter int LENGTH_FIELD_BITS  = 3,
	parameter int STREAM_LENGTH_BITS = 30
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [2:0]                         mode,
	input  logic [hbp_pkg::SYMBOL_BITS-1:0]    symbol,
	input  logic [hbp_pkg::CODE_LEN_BITS-1:0]  code_length,
	input  logic [hbp_pkg::MAX_CODE_BITS-1:0]  code_bits,
	input  logic [hbp_pkg::COUNT_IN_BITS-1:0]  entry_count,
	input  logic [hbp_pkg::STREAM_IN_BITS-1:0] stream_length,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [hbp_pkg::BYTE_BITS-1:0]      out_byte,
	output logic                               last_of_run
);

	localparam int ENTRY_W = hbp_pkg::SYMBOL_BITS + LENGTH_FIELD_BITS + hbp_pkg::MAX_CODE_BITS;
	localparam int HDR_W   = (COUNT_FIELD_BITS > STREAM_LENGTH_BITS) ? COUNT_FIELD_BITS
		: STREAM_LENGTH_BITS;
	localparam int PUSH_W  = (HDR_W > ENTRY_W) ? HDR_W : ENTRY_W;
	localparam int LEN_W   = $clog2(PUSH_W + 1);
	localparam int JOB_W   = 1 + LEN_W + PUSH_W;

	logic              fe_valid;
	logic              fe_flush;
	logic [LEN_W-1:0]  fe_len;
	logic [PUSH_W-1:0] fe_bits;
	logic              q_full;
	logic              q_empty;
	logic              q_pop;
	logic [JOB_W-1:0]  q_rd_data;

	hbp_front #(
		.COUNT_FIELD_BITS   (COUNT_FIELD_BITS),
		.LENGTH_FIELD_BITS  (LENGTH_FIELD_BITS),
		.STREAM_LENGTH_BITS (STREAM_LENGTH_BITS),
		.PUSH_W             (PUSH_W),
		.LEN_W              (LEN_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.symbol        (symbol),
		.code_length   (code_length),
		.code_bits     (code_bits),
		.entry_count   (entry_count),
		.stream_length (stream_length),
		.job_valid     (fe_valid),
		.job_ready     (!q_full),
		.job_flush     (fe_flush),
		.job_len       (fe_len),
		.job_bits      (fe_bits)
	);

	hbp_queue #(
		.DATA_W (JOB_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fe_valid),
		.push_data ({fe_flush, fe_len, fe_bits}),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rd_data),
		.empty     (q_empty)
	);

	hbp_back #(
		.PUSH_W (PUSH_W),
		.LEN_W  (LEN_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_empty   (q_empty),
		.job_flush   (q_rd_data[JOB_W-1]),
		.job_len     (q_rd_data[JOB_W-2:PUSH_W]),
		.job_bits    (q_rd_data[PUSH_W-1:0]),
		.job_pop     (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule
